>>> rtl/gsp_pkg.sv
// shared types, constants and the latin-1 to septet map for the septet packer
`default_nettype none

package gsp_pkg;

	localparam int SeptetW = 7;
	localparam int OctetW  = 8;
	localparam int PosW    = 3;

	localparam logic [SeptetW-1:0] UNKNOWN_SEPTET = 7'h3f;
	localparam logic [OctetW-1:0]  QUESTION_MARK  = 8'h3f;
	localparam logic [PosW-1:0]    LAST_POS       = 3'd7;

	// one mapped character on its way from the front to the back
	typedef struct packed {
		logic [SeptetW-1:0] septet;
		logic               last;
	} sym_t;

	// first match of the default alphabet, question mark and unmatched characters give the unknown code
	function automatic logic [SeptetW-1:0] to_septet(input logic [OctetW-1:0] c);
		logic [SeptetW-1:0] s;
		s = UNKNOWN_SEPTET;
		if (c == QUESTION_MARK) begin
			s = UNKNOWN_SEPTET;
		end else if ((c >= 8'h20 && c <= 8'h23) || (c >= 8'h25 && c <= 8'h3e) ||
		             (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) begin
			// printable ascii in these ranges keeps its own code
			s = c[SeptetW-1:0];
		end else begin
			unique case (c)
				8'h40:   s = 7'd0;
				8'ha3:   s = 7'd1;
				8'h24:   s = 7'd2;
				8'ha5:   s = 7'd3;
				8'he8:   s = 7'd4;
				8'he9:   s = 7'd5;
				8'hf9:   s = 7'd6;
				8'hec:   s = 7'd7;
				8'hf2:   s = 7'd8;
				8'hc7:   s = 7'd9;
				8'h0a:   s = 7'd10;
				8'hd8:   s = 7'd11;
				8'hf8:   s = 7'd12;
				8'h0d:   s = 7'd13;
				8'hc5:   s = 7'd14;
				8'he5:   s = 7'd15;
				8'h5f:   s = 7'd17;
				8'hc6:   s = 7'd28;
				8'he6:   s = 7'd29;
				8'hdf:   s = 7'd30;
				8'hc9:   s = 7'd31;
				8'ha4:   s = 7'd36;
				8'ha1:   s = 7'd64;
				8'hc4:   s = 7'd91;
				8'hd6:   s = 7'd92;
				8'hd1:   s = 7'd93;
				8'hdc:   s = 7'd94;
				8'ha7:   s = 7'd95;
				8'hbf:   s = 7'd96;
				8'he4:   s = 7'd123;
				8'hf6:   s = 7'd124;
				8'hf1:   s = 7'd125;
				8'hfc:   s = 7'd126;
				8'he0:   s = 7'd127;
				default: s = UNKNOWN_SEPTET;
			endcase
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gsp_front.sv
// front stage: takes characters, maps them to septets and registers them
`default_nettype none

module gsp_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [7:0]            char_code,
	input  wire                   last_char,
	output logic                  sym_valid,
	output gsp_pkg::sym_t         sym,
	input  wire                   sym_full
);
	import gsp_pkg::*;

	logic valid_s1;
	sym_t sym_s1;
	logic advance;

	// stage moves on when empty or when the queue takes what it holds
	assign advance  = !valid_s1 || !sym_full;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sym_s1   <= '0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				sym_s1.septet <= to_septet(char_code);
				sym_s1.last   <= last_char;
			end
		end
	end

	assign sym_valid = valid_s1;
	assign sym       = sym_s1;

endmodule

`default_nettype wire

>>> rtl/gsp_queue.sv
// two-entry queue between the front and the packing back end
`default_nettype none

module gsp_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  gsp_pkg::sym_t         push_sym,
	output logic                  full,
	input  wire                   pop,
	output logic                  pop_valid,
	output gsp_pkg::sym_t         pop_sym
);
	import gsp_pkg::*;

	sym_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_sym   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/gsp_back.sv
// back end: packs septets into octets and drives the output register
`default_nettype none

module gsp_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [2:0]            cfg_wdata,
	input  wire                   sym_valid,
	input  gsp_pkg::sym_t         sym,
	output logic                  sym_pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [7:0]            octet,
	output logic                  last_octet
);
	import gsp_pkg::*;

	logic [PosW-1:0]      fill_q;
	logic [PosW-1:0]      pos_q;
	logic [OctetW-1:0]    pend_q;
	logic                 flush_q;
	logic [OctetW-1:0]    flush_oct_q;
	logic                 out_valid_q;
	logic [OctetW-1:0]    octet_q;
	logic                 last_q;

	logic                 out_free;
	logic [14:0]          acc;
	logic                 emit;
	logic [PosW-1:0]      new_pos;
	logic [OctetW-1:0]    new_pend;

	assign out_free = !out_valid_q || !out_stall;
	assign sym_pop  = sym_valid && out_free && !flush_q && !cfg_we;

	always_comb begin
		acc      = {7'd0, pend_q} | ({8'd0, sym.septet} << pos_q);
		emit     = (pos_q != 3'd0);
		new_pos  = emit ? (pos_q - 3'd1) : LAST_POS;
		new_pend = emit ? {1'b0, acc[14:8]} : acc[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			pend_q      <= '0;
			flush_q     <= 1'b0;
			flush_oct_q <= '0;
			out_valid_q <= 1'b0;
			octet_q     <= '0;
			last_q      <= 1'b0;
		end else if (cfg_we) begin
			// new fill restarts the message
			fill_q  <= cfg_wdata;
			pos_q   <= cfg_wdata;
			pend_q  <= '0;
			flush_q <= 1'b0;
		end else if (out_free) begin
			if (flush_q) begin
				out_valid_q <= 1'b1;
				octet_q     <= flush_oct_q;
				last_q      <= 1'b1;
				flush_q     <= 1'b0;
			end else if (sym_valid) begin
				out_valid_q <= emit || sym.last;
				octet_q     <= emit ? acc[7:0] : new_pend;
				if (sym.last) begin
					// partial octet left over goes out on the next slot
					if (emit && new_pos != 3'd0) begin
						last_q      <= 1'b0;
						flush_q     <= 1'b1;
						flush_oct_q <= new_pend;
					end else begin
						last_q <= 1'b1;
					end
					pos_q  <= fill_q;
					pend_q <= '0;
				end else begin
					last_q <= 1'b0;
					pos_q  <= new_pos;
					pend_q <= new_pend;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign octet      = octet_q;
	assign last_octet = last_q;

endmodule

`default_nettype wire

>>> rtl/gsm_septet_packer.sv
// top level of the gsm default-alphabet septet packer
`default_nettype none

// takes one latin-1 character per request and packs its 7-bit gsm default
// alphabet code lsb first into octets, after fill_bits zero bits at the bottom
// of the first octet. a character is taken every clock cycle while the front
// does not stall on a full queue; each request yields one octet except when
// the position wraps, and the final character of a message may yield two, in
// which case the back end sends the flushed partial octet in an extra output
// slot. a request passes through the front map register, the two-entry queue
// and the output register. the map is gsp_pkg::to_septet in the front stage.
// writing fill_bits restarts the packer and must be done while idle.
module gsm_septet_packer (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire  [2:0] cfg_wdata,
	// character requests
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] char_code,
	input  wire        last_char,
	// packed octets
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] octet,
	output logic       last_octet
);
	import gsp_pkg::*;

	// front to queue
	logic sym_valid;
	sym_t front_sym;
	logic q_full;

	// queue to back end
	logic q_valid;
	sym_t q_sym;
	logic q_pop;

	// map stage, stalls only when the queue is full
	gsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.sym_valid (sym_valid),
		.sym       (front_sym),
		.sym_full  (q_full)
	);

	// short queue so front and back stall independently
	gsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sym_valid),
		.push_sym  (front_sym),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_sym   (q_sym)
	);

	// bit packer and output register
	gsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sym_valid  (q_valid),
		.sym        (q_sym),
		.sym_pop    (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.octet      (octet),
		.last_octet (last_octet)
	);

endmodule

`default_nettype wire

>>> test/gsm_septet_packer_tb.sv
// self-checking testbench for the gsm septet packer: directed table, then random messages
`timescale 1ns / 1ps

module gsm_septet_packer_tb;
	import gsp_pkg::*;

	localparam int ALPHA_SIZE = 128;
	localparam int DIRECTED_ROWS = 23;
	localparam int PHASE_CHARS = 317;
	localparam int SETTLE_CYCLES = 10;

	// one octet the packer is due to deliver
	typedef struct packed {
		logic [7:0] octet;
		logic       last;
	} octet_t;

	// one row of the directed table: optional fill write, then one character request;
	// typed rows carry the single final octet that can be read off directly
	typedef struct packed {
		logic       wr;
		logic [2:0] fill;
		logic [7:0] ch;
		logic       lst;
		logic       typed;
		logic [7:0] oct;
	} row_t;

	// default alphabet, septet code is the index, latin-1 value is the entry
	localparam logic [7:0] GSM_ALPHA [ALPHA_SIZE] = '{
		8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
		8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
		8'h3f, 8'h5f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f,
		8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'hc6, 8'he6, 8'hdf, 8'hc9,
		8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
		8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
		8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
		8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
		8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
		8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
		8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
		8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
		8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
	};

	// wr fill ch lst typed oct
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// single-character messages at zero fill: the octet is the septet itself
		'{1'b1, 3'd0, 8'h41, 1'b1, 1'b1, 8'h41},
		'{1'b0, 3'd0, 8'h00, 1'b1, 1'b1, 8'h3f},   // lowest code, unmapped
		'{1'b0, 3'd0, 8'hff, 1'b1, 1'b1, 8'h3f},   // highest code, unmapped
		'{1'b0, 3'd0, 8'h3f, 1'b1, 1'b1, 8'h3f},   // question mark
		'{1'b0, 3'd0, 8'h40, 1'b1, 1'b1, 8'h00},   // at sign, septet zero
		'{1'b0, 3'd0, 8'he0, 1'b1, 1'b1, 8'h7f},   // top septet
		'{1'b0, 3'd0, 8'h80, 1'b1, 1'b1, 8'h3f},
		'{1'b0, 3'd0, 8'h24, 1'b1, 1'b1, 8'h02},
		// eight septets fill seven octets exactly, no partial octet to flush
		'{1'b0, 3'd0, 8'h61, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h62, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h63, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h64, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h65, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h66, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h67, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 8'h68, 1'b1, 1'b0, 8'h00},
		// widest fill, one character gives two octets
		'{1'b1, 3'd7, 8'h55, 1'b1, 1'b0, 8'h00},
		'{1'b1, 3'd1, 8'h48, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd1, 8'h69, 1'b1, 1'b0, 8'h00},
		// message abandoned by a fill write
		'{1'b1, 3'd3, 8'h78, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd3, 8'h79, 1'b0, 1'b0, 8'h00},
		'{1'b1, 3'd0, 8'h7a, 1'b1, 1'b1, 8'h7a},
		'{1'b1, 3'd7, 8'hff, 1'b1, 1'b0, 8'h00}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] octet;
	logic       last_octet;

	// octets still to come, oldest first
	octet_t octets_due [$];

	// packer state as the testbench sees it
	logic [2:0] fill_now;
	logic [7:0] pend_bits;
	logic [2:0] pend_pos;

	int idle_in_pct;
	int idle_out_pct;
	int errors;

	gsm_septet_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.octet      (octet),
		.last_octet (last_octet)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// first match in the alphabet; question mark and misses give the unknown code
	function automatic logic [6:0] septet_of(input logic [7:0] c);
		logic [6:0] s;
		s = UNKNOWN_SEPTET;
		if (c != QUESTION_MARK) begin
			// walk downwards so the lowest matching index wins
			for (int i = ALPHA_SIZE - 1; i >= 0; i--) begin
				if (GSM_ALPHA[i] == c) begin
					s = 7'(i);
				end
			end
		end
		return s;
	endfunction

	// new message: fill bits already pending as zeros
	task automatic restart_message();
		pend_bits = 8'd0;
		pend_pos  = fill_now;
	endtask

	// pack one character, queueing the octets it completes when keep is set
	task automatic pack_char(input logic [7:0] c, input logic lst, input logic keep);
		logic [14:0] acc;
		octet_t      o;
		acc = {7'd0, pend_bits} | ({8'd0, septet_of(c)} << pend_pos);
		if (pend_pos != 3'd0) begin
			// octet complete; it is the final one if nothing is left over
			o.octet = acc[7:0];
			o.last  = lst && (pend_pos == 3'd1);
			if (keep) begin
				octets_due.push_back(o);
			end
			pend_bits = {1'b0, acc[14:8]};
			pend_pos  = pend_pos - 3'd1;
		end else begin
			pend_bits = acc[7:0];
			pend_pos  = 3'd7;
		end
		if (lst) begin
			// flush the partial octet
			if (pend_pos != 3'd0) begin
				o.octet = pend_bits;
				o.last  = 1'b1;
				if (keep) begin
					octets_due.push_back(o);
				end
			end
			restart_message();
		end
	endtask

	// write the fill register once the packer has drained
	task automatic write_fill(input logic [2:0] v);
		in_valid <= 1'b0;
		while (octets_due.size() != 0) begin
			@(posedge clk);
		end
		// characters that complete no octet may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		fill_now = v;
		restart_message();
	endtask

	// offer one character request, with random gaps, until it is taken
	task automatic send_char(input logic [7:0] c, input logic lst, input logic keep);
		while ($urandom_range(0, 99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= lst;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pack_char(c, lst, keep);
	endtask

	// octet sink: random stall, compare each delivered octet with the oldest due
	initial begin
		octet_t due;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (octets_due.size() == 0) begin
					$error("octet %02h (last_octet %0b) with no octet due", octet, last_octet);
					errors++;
				end else begin
					due = octets_due.pop_front();
					if (octet !== due.octet) begin
						$error("octet: expected %02h, got %02h", due.octet, octet);
						errors++;
					end
					if (last_octet !== due.last) begin
						$error("last_octet: expected %0b, got %0b", due.last, last_octet);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < idle_out_pct);
		end
	end

	// stimulus
	initial begin
		row_t       r;
		int         len;
		int         sent;
		logic       cut;
		logic       first;
		logic       need_write;
		logic [7:0] c;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 3'd0;
		in_valid     = 1'b0;
		char_code    = 8'd0;
		last_char    = 1'b0;
		errors       = 0;
		idle_in_pct  = 0;
		idle_out_pct = 0;
		fill_now     = 3'd0;
		restart_message();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		idle_in_pct  = 27;
		idle_out_pct = 56;
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			r = DIRECTED[i];
			if (r.wr) begin
				write_fill(r.fill);
			end
			if (r.typed) begin
				octets_due.push_back('{octet: r.oct, last: 1'b1});
			end
			send_char(r.ch, r.lst, !r.typed);
		end

		// random messages in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			unique case (ph)
				0: begin
					idle_in_pct  = 27;
					idle_out_pct = 56;
				end
				1: begin
					idle_in_pct  = 56;
					idle_out_pct = 27;
				end
				default: begin
					idle_in_pct  = 0;
					idle_out_pct = 0;
				end
			endcase
			sent       = 0;
			first      = 1'b1;
			need_write = 1'b0;
			while (sent < PHASE_CHARS) begin
				if (first) begin
					// extremes of fill open the first two phases
					write_fill(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom_range(0, 7)));
				end else if (need_write || $urandom_range(0, 5) == 0) begin
					write_fill(3'($urandom_range(0, 7)));
				end
				first = 1'b0;
				// mostly short messages, now and then a long one
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
				// some messages are cut short and abandoned by a fill write
				cut = ($urandom_range(0, 11) == 0);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						c = 8'($urandom_range(0, 255));
					end else begin
						c = GSM_ALPHA[$urandom_range(0, ALPHA_SIZE - 1)];
					end
					send_char(c, (k == len - 1) && !cut, 1'b1);
					sent++;
				end
				need_write = cut;
			end
		end

		in_valid <= 1'b0;
		while (octets_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/gsp_pkg.sv
rtl/gsp_front.sv
rtl/gsp_queue.sv
rtl/gsp_back.sv
rtl/gsm_septet_packer.sv
test/gsm_septet_packer_tb.sv
